// File: hw/rtl/sit_pkg.sv
// shared types and constants for the segment intersection test core
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  typedef enum logic [1:0] {
    CASE_GENERAL   = 2'd0,
    CASE_PARALLEL  = 2'd1,
    CASE_ONE_VERT  = 2'd2,
    CASE_BOTH_VERT = 2'd3
  } case_code_t;

  typedef struct packed {
    coord_t seg_a_start_x;
    coord_t seg_a_start_y;
    coord_t seg_a_end_x;
    coord_t seg_a_end_y;
    coord_t seg_b_start_x;
    coord_t seg_b_start_y;
    coord_t seg_b_end_x;
    coord_t seg_b_end_y;
  } request_t;

  typedef struct packed {
    logic       intersects;
    case_code_t case_code;
  } result_t;

  // classification flags that ride alongside the cross products
  typedef struct packed {
    logic vert_a;
    logic vert_b;
    logic both_hit;
    logic x_overlap;
  } side_t;

endpackage

// File: hw/rtl/segment_intersection_test_core.sv
// top level of the segment intersection test core
// Takes one pair of segments per clock and returns its verdict as a one-cycle
// done strobe with result; the receiver cannot stall results, so each verdict
// must be taken in the cycle that done is high. Requests are never held off in
// operation: busy is high only during reset and for the cycle after it. The
// four register stages are the coordinate differences, the product registers,
// the cross product subtraction and the final classification.
module segment_intersection_test_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sit_pkg::request_t request,
  output logic              done,
  output sit_pkg::result_t  result
);

  logic accept;

  logic           s1_valid;
  sit_pkg::diff_t s1_dax, s1_day, s1_dbx, s1_dby, s1_rx, s1_ry;
  sit_pkg::side_t s1_side;
  logic           s2_valid;
  sit_pkg::side_t s2_side;
  logic           s3_valid;
  sit_pkg::side_t s3_side;

  sit_pkg::cross_t den, un, tn;

  sit_pkg::side_t side_next;
  sit_pkg::coord_t ay_lo, ay_hi, by_lo, by_hi, ax_lo, ax_hi, bx_lo, bx_hi;
  sit_pkg::result_t result_next;
  logic den_zero, den_neg, t_in, u_in;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // stage 1: differences and span checks
  always_comb begin
    ax_lo = (request.seg_a_start_x < request.seg_a_end_x) ? request.seg_a_start_x
                                                           : request.seg_a_end_x;
    ax_hi = (request.seg_a_start_x < request.seg_a_end_x) ? request.seg_a_end_x
                                                           : request.seg_a_start_x;
    bx_lo = (request.seg_b_start_x < request.seg_b_end_x) ? request.seg_b_start_x
                                                           : request.seg_b_end_x;
    bx_hi = (request.seg_b_start_x < request.seg_b_end_x) ? request.seg_b_end_x
                                                           : request.seg_b_start_x;
    ay_lo = (request.seg_a_start_y < request.seg_a_end_y) ? request.seg_a_start_y
                                                           : request.seg_a_end_y;
    ay_hi = (request.seg_a_start_y < request.seg_a_end_y) ? request.seg_a_end_y
                                                           : request.seg_a_start_y;
    by_lo = (request.seg_b_start_y < request.seg_b_end_y) ? request.seg_b_start_y
                                                           : request.seg_b_end_y;
    by_hi = (request.seg_b_start_y < request.seg_b_end_y) ? request.seg_b_end_y
                                                           : request.seg_b_start_y;
    side_next.vert_a    = (request.seg_a_start_x == request.seg_a_end_x);
    side_next.vert_b    = (request.seg_b_start_x == request.seg_b_end_x);
    side_next.both_hit  = (request.seg_a_start_x == request.seg_b_start_x) &&
                          !((ay_lo > by_hi) || (ay_hi < by_lo));
    side_next.x_overlap = !((ax_lo > bx_hi) || (ax_hi < bx_lo));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_dax  <= sit_pkg::DIFF_WIDTH'(request.seg_a_end_x) -
               sit_pkg::DIFF_WIDTH'(request.seg_a_start_x);
    s1_day  <= sit_pkg::DIFF_WIDTH'(request.seg_a_end_y) -
               sit_pkg::DIFF_WIDTH'(request.seg_a_start_y);
    s1_dbx  <= sit_pkg::DIFF_WIDTH'(request.seg_b_end_x) -
               sit_pkg::DIFF_WIDTH'(request.seg_b_start_x);
    s1_dby  <= sit_pkg::DIFF_WIDTH'(request.seg_b_end_y) -
               sit_pkg::DIFF_WIDTH'(request.seg_b_start_y);
    s1_rx   <= sit_pkg::DIFF_WIDTH'(request.seg_b_start_x) -
               sit_pkg::DIFF_WIDTH'(request.seg_a_start_x);
    s1_ry   <= sit_pkg::DIFF_WIDTH'(request.seg_b_start_y) -
               sit_pkg::DIFF_WIDTH'(request.seg_a_start_y);
    s1_side <= side_next;
    s2_side <= s1_side;
    s3_side <= s2_side;
    result  <= result_next;
  end

  // stages 2 and 3: cross products
  sit_cross_unit u_den (
    .clk(clk), .px(s1_dax), .py(s1_day), .qx(s1_dbx), .qy(s1_dby), .cross_prod(den)
  );

  sit_cross_unit u_un (
    .clk(clk), .px(s1_rx), .py(s1_ry), .qx(s1_dax), .qy(s1_day), .cross_prod(un)
  );

  sit_cross_unit u_tn (
    .clk(clk), .px(s1_rx), .py(s1_ry), .qx(s1_dbx), .qy(s1_dby), .cross_prod(tn)
  );

  // stage 4: case code, and parameters strictly inside the open unit interval
  always_comb begin
    den_zero = (den == '0);
    den_neg  = den[sit_pkg::CROSS_WIDTH-1];
    t_in     = den_neg ? ((tn < 0) && (tn > den)) : ((tn > 0) && (tn < den));
    u_in     = den_neg ? ((un < 0) && (un > den)) : ((un > 0) && (un < den));
    if (s3_side.vert_a && s3_side.vert_b) begin
      result_next.case_code  = sit_pkg::CASE_BOTH_VERT;
      result_next.intersects = s3_side.both_hit;
    end else if (!s3_side.vert_a && !s3_side.vert_b && den_zero) begin
      result_next.case_code  = sit_pkg::CASE_PARALLEL;
      result_next.intersects = (un == '0) && s3_side.x_overlap;
    end else begin
      result_next.case_code  = (s3_side.vert_a || s3_side.vert_b) ? sit_pkg::CASE_ONE_VERT
                                                                  : sit_pkg::CASE_GENERAL;
      result_next.intersects = !den_zero && t_in && u_in;
    end
  end

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("accepted request did not complete after four cycles");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##4 !done)
    else $error("done without a matching request");

  a_busy_only_after_reset: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy outside the cycle after reset");

  a_parallel_flags: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_side.vert_a && !s3_side.vert_b && den_zero) |=>
      (result.case_code == sit_pkg::CASE_PARALLEL))
    else $error("parallel pair not classified as parallel");

endmodule

// File: hw/rtl/sit_cross_unit.sv
// two-stage exact 2d cross product p.x * q.y - p.y * q.x
module sit_cross_unit (
  input  logic           clk,
  input  sit_pkg::diff_t px,
  input  sit_pkg::diff_t py,
  input  sit_pkg::diff_t qx,
  input  sit_pkg::diff_t qy,
  output sit_pkg::cross_t cross_prod
);

  sit_pkg::prod_t m0;
  sit_pkg::prod_t m1;

  always_ff @(posedge clk) begin
    m0         <= sit_pkg::PROD_WIDTH'(px) * sit_pkg::PROD_WIDTH'(qy);
    m1         <= sit_pkg::PROD_WIDTH'(py) * sit_pkg::PROD_WIDTH'(qx);
    cross_prod <= sit_pkg::CROSS_WIDTH'(m0) - sit_pkg::CROSS_WIDTH'(m1);
  end

endmodule

// File: verif/tb.sv
// testbench for the segment intersection test core: queued requests, exact verdict predictor
`timescale 1ns / 100ps

module tb;
  import sit_pkg::*;

  localparam int RANDOM_PAIRS = 1900;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;

  request_t pending_pairs[$];
  result_t  expected_verdicts[$];
  int       idle_left = 0;
  int       calm_left = 0;
  int       fault_count = 0;
  int       cycle_count = 0;

  segment_intersection_test_core DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint lo2(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint hi2(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // exact verdict: the cross products fit comfortably in 64 bits
  function automatic result_t predict_verdict(request_t r);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    longint dax, day, dbx, dby, rx, ry, den, un, tn;
    logic   vert_a, vert_b, hit;
    result_t v;
    ax1 = r.seg_a_start_x;
    ay1 = r.seg_a_start_y;
    ax2 = r.seg_a_end_x;
    ay2 = r.seg_a_end_y;
    bx1 = r.seg_b_start_x;
    by1 = r.seg_b_start_y;
    bx2 = r.seg_b_end_x;
    by2 = r.seg_b_end_y;
    dax = ax2 - ax1;
    day = ay2 - ay1;
    dbx = bx2 - bx1;
    dby = by2 - by1;
    rx = bx1 - ax1;
    ry = by1 - ay1;
    vert_a = (dax == 0);
    vert_b = (dbx == 0);
    den = dax * dby - day * dbx;
    un = rx * day - ry * dax;
    tn = rx * dby - ry * dbx;
    if (vert_a && vert_b) begin
      v.case_code = CASE_BOTH_VERT;
      hit = (ax1 == bx1) && !(lo2(ay1, ay2) > hi2(by1, by2) || hi2(ay1, ay2) < lo2(by1, by2));
    end else if (!vert_a && !vert_b && den == 0) begin
      v.case_code = CASE_PARALLEL;
      hit = (un == 0) && !(lo2(ax1, ax2) > hi2(bx1, bx2) || hi2(ax1, ax2) < lo2(bx1, bx2));
    end else begin
      v.case_code = (vert_a || vert_b) ? CASE_ONE_VERT : CASE_GENERAL;
      if (den == 0) begin
        hit = 1'b0;
      end else begin
        if (den < 0) begin
          den = -den;
          tn = -tn;
          un = -un;
        end
        hit = (tn > 0) && (den - tn > 0) && (un > 0) && (den - un > 0);
      end
    end
    v.intersects = hit;
    return v;
  endfunction

  function automatic request_t make_pair(int ax1, int ay1, int ax2, int ay2,
                                         int bx1, int by1, int bx2, int by2);
    request_t r;
    r.seg_a_start_x = coord_t'(ax1);
    r.seg_a_start_y = coord_t'(ay1);
    r.seg_a_end_x   = coord_t'(ax2);
    r.seg_a_end_y   = coord_t'(ay2);
    r.seg_b_start_x = coord_t'(bx1);
    r.seg_b_start_y = coord_t'(by1);
    r.seg_b_end_x   = coord_t'(bx2);
    r.seg_b_end_y   = coord_t'(by2);
    return r;
  endfunction

  function automatic int signed_draw(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic int full_coord();
    return int'(coord_t'($urandom));
  endfunction

  function automatic request_t random_pair();
    int c[8];
    int cx, cy, dx, dy, ex, ey, k, m;
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (c[i]) c[i] = full_coord();
      end
      2, 3: begin
        foreach (c[i]) c[i] = signed_draw(6);
      end
      4: begin
        // one vertical segment against a random one
        foreach (c[i]) c[i] = ($urandom_range(0, 1) != 0) ? signed_draw(40) : full_coord();
        if ($urandom_range(0, 1) != 0) c[2] = c[0];
        else c[6] = c[4];
      end
      5: begin
        foreach (c[i]) c[i] = ($urandom_range(0, 3) != 0) ? signed_draw(30) : full_coord();
        c[2] = c[0];
        c[4] = ($urandom_range(0, 3) != 0) ? c[0] : c[4];
        c[6] = c[4];
      end
      6: begin
        // parallel, often collinear
        cx = signed_draw(1000);
        cy = signed_draw(1000);
        dx = signed_draw(20);
        dy = signed_draw(20);
        if (dx == 0) dx = 3;
        k = signed_draw(3);
        m = signed_draw(3);
        if (m == 0) m = -2;
        c[0] = cx;
        c[1] = cy;
        c[2] = cx + dx;
        c[3] = cy + dy;
        c[4] = cx + k * dx;
        c[5] = cy + k * dy + (($urandom_range(0, 2) == 0) ? signed_draw(2) : 0);
        c[6] = c[4] + m * dx;
        c[7] = c[5] + m * dy;
      end
      7: begin
        foreach (c[i]) c[i] = extreme_coord();
      end
      default: begin
        // two segments through a shared point, ends sometimes on it
        cx = signed_draw(20000);
        cy = signed_draw(20000);
        dx = signed_draw(($urandom_range(0, 1) != 0) ? 10000 : 8);
        dy = signed_draw(($urandom_range(0, 1) != 0) ? 10000 : 8);
        ex = signed_draw(($urandom_range(0, 1) != 0) ? 10000 : 8);
        ey = signed_draw(($urandom_range(0, 1) != 0) ? 10000 : 8);
        k = ($urandom_range(0, 4) == 0) ? 0 : 1;
        c[0] = cx - k * dx;
        c[1] = cy - k * dy;
        c[2] = cx + dx;
        c[3] = cy + dy;
        c[4] = cx - ex;
        c[5] = cy - ey;
        c[6] = cx + ex;
        c[7] = cy + ey;
      end
    endcase
    return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic record_fault(string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) expected_verdicts.push_back(predict_verdict(request));
      if (start && busy) begin
      end else if (idle_left != 0) begin
        start <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_pairs.size() != 0) begin
        request <= pending_pairs.pop_front();
        start <= 1'b1;
        idle_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_verdicts.size() == 0) begin
        record_fault($sformatf("unexpected result: intersects=%0b case_code=%0d",
                               result.intersects, result.case_code));
      end else begin
        want = expected_verdicts.pop_front();
        if (result.intersects !== want.intersects || result.case_code !== want.case_code)
          record_fault($sformatf("mismatch: expected intersects=%0b case_code=%0d, got %0b %0d",
                                 want.intersects, want.case_code,
                                 result.intersects, result.case_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // directed requests
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 10, 0, 20, 0, 10));
    pending_pairs.push_back(make_pair(0, 0, 0, 10, 1, 0, 1, 10));
    pending_pairs.push_back(make_pair(0, 0, 0, 10, 0, 11, 0, 20));
    pending_pairs.push_back(make_pair(0, 0, 16, 16, 16, 16, 32, 32));
    pending_pairs.push_back(make_pair(0, 0, 16, 16, 0, 1, 16, 17));
    pending_pairs.push_back(make_pair(0, 0, 16, 16, 32, 32, 48, 48));
    pending_pairs.push_back(make_pair(0, 0, 32, 16, 48, 24, 16, 8));
    pending_pairs.push_back(make_pair(-16, -16, 16, 16, -16, 16, 16, -16));
    pending_pairs.push_back(make_pair(0, 0, 16, 16, 16, 16, 32, 0));
    pending_pairs.push_back(make_pair(0, 0, 16, 16, 20, 0, 40, -16));
    pending_pairs.push_back(make_pair(0, -16, 0, 16, -16, 0, 16, 0));
    pending_pairs.push_back(make_pair(-16, 0, 16, 0, 0, -16, 0, 16));
    pending_pairs.push_back(make_pair(0, 0, 0, 16, -16, 0, 16, 0));
    pending_pairs.push_back(make_pair(0, -16, 0, 16, 0, 0, 16, 5));
    pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 16, 16));
    pending_pairs.push_back(make_pair(0, 0, 16, 16, 5, 5, 5, 5));
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(make_pair(-32768, -32768, 0, 0, 0, 0, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 32767, -32768, -32768, -32768, 0, -32768, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    repeat (RANDOM_PAIRS) pending_pairs.push_back(random_pair());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || start || expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
